// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define FDEC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define FDEC_ASSERT_IMPL(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fdec_pkg.sv =====
// ----------------------------------------------------------------------------
// fdec_pkg
// Shared types, sizes and codes of the fetch/decode/execute core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdec_pkg;

	// Store depths (powers of two; addresses use the low bits)
	localparam int NUM_REGS   = 32;
	localparam int DATA_DEPTH = 256;
	localparam int PROG_DEPTH = 256;
	localparam int REG_AW     = $clog2(NUM_REGS);
	localparam int DATA_AW    = $clog2(DATA_DEPTH);
	localparam int PROG_AW    = $clog2(PROG_DEPTH);

	// Item functions
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_PROG = 2'd1;
	localparam logic [1:0] FUNC_DATA = 2'd2;

	// Opcodes
	localparam logic [7:0] OPC_NOP = 8'h00;
	localparam logic [7:0] OPC_LDI = 8'h01;
	localparam logic [7:0] OPC_MOV = 8'h02;
	localparam logic [7:0] OPC_OUT = 8'h03;
	localparam logic [7:0] OPC_IN  = 8'h04;
	localparam logic [7:0] OPC_JMP = 8'h16;

	// Phase codes as reported on the result
	localparam logic [1:0] PHC_FETCH   = 2'd0;
	localparam logic [1:0] PHC_DECODE  = 2'd1;
	localparam logic [1:0] PHC_EXECUTE = 2'd2;

	typedef enum logic [2:0] {
		PH_FETCH   = 3'b001,
		PH_DECODE  = 3'b010,
		PH_EXECUTE = 3'b100
	} phase_t;

	// Work left for the write-back stage
	typedef enum logic [7:0] {
		ACT_NONE  = 8'b0000_0001,
		ACT_FETCH = 8'b0000_0010,
		ACT_LDI   = 8'b0000_0100,
		ACT_MOV   = 8'b0000_1000,
		ACT_IN    = 8'b0001_0000,
		ACT_OUT   = 8'b0010_0000,
		ACT_DWR   = 8'b0100_0000,
		ACT_FAULT = 8'b1000_0000
	} act_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  load_addr;
		logic [23:0] prog_word;
		logic [7:0]  byte_in;
	} in_t;

	typedef struct packed {
		logic [7:0] pc_now;
		logic [1:0] phase_now;
		logic [7:0] opcode_now;
		logic       io_write_valid;
		logic [7:0] io_write_addr;
		logic [7:0] io_write_data;
		logic       fault_reset;
	} out_t;

	// Front end to write-back stage
	typedef struct packed {
		act_t       act;
		logic [7:0] pc;
		logic [1:0] phase;
		logic [7:0] opcode;
		logic [7:0] op1;
		logic [7:0] op2;
		logic [7:0] load_addr;
		logic [7:0] byte_in;
	} ctl_t;

	// Write-back stage to register file and data store
	typedef struct packed {
		logic               clear;
		logic               reg_we;
		logic [REG_AW-1:0]  reg_addr;
		logic [7:0]         reg_data;
		logic               dat_we;
		logic [DATA_AW-1:0] dat_addr;
		logic [7:0]         dat_data;
	} exec_wr_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_FETCH:   code = PHC_FETCH;
			PH_DECODE:  code = PHC_DECODE;
			PH_EXECUTE: code = PHC_EXECUTE;
			default:    code = PHC_FETCH;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fetch_decode_execute_core.sv =====
// ----------------------------------------------------------------------------
// fetch_decode_execute_core
// Three-phase fetch/decode/execute core with program loader, register file
// and data store.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle unless a stalled write-back beat blocks it,
// and each beat returns one result beat: the sequencer updates the program
// counter, phase and decoded fields at acceptance and issues the reads of the
// program store, register file and data store; then the write-back stage
// writes the register file or data store and loads the output register. A
// write landing on the same edge as a later read is bypassed. Never-written
// entries read as zero through valid bits held in flops, so reset needs no
// clearing pass and an unknown opcode clears the register file and data store.
// The program store keeps its contents across an unknown-opcode reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fetch_decode_execute_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fdec_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fdec_pkg::out_t out_data
);

	logic accept;
	logic s2_adv;
	logic s2_vld_q;
	logic out_vld_q;
	logic fetch_pend;
	logic fetch_done;

	fdec_pkg::ctl_t     ctl_next;
	fdec_pkg::ctl_t     ctl_s2;
	fdec_pkg::exec_wr_t wr;
	fdec_pkg::out_t     res;
	fdec_pkg::out_t     out_q;

	logic [fdec_pkg::PROG_AW-1:0] prog_raddr;
	logic [23:0]                  prog_rdata;
	logic [fdec_pkg::REG_AW-1:0]  rd_reg_addr;
	logic [fdec_pkg::DATA_AW-1:0] rd_dat_addr;
	logic [7:0]                   reg_rdata;
	logic [7:0]                   dat_rdata;

	// Handshake: write-back stage moves on when the output register frees
	assign s2_adv     = s2_vld_q && (!out_vld_q || out_ready);
	assign in_ready   = !s2_vld_q || s2_adv;
	assign accept     = in_valid && in_ready;
	assign fetch_pend = s2_vld_q && (ctl_s2.act == fdec_pkg::ACT_FETCH);
	assign fetch_done = fetch_pend && s2_adv;

	fdec_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (in_data),
		.fetch_pend  (fetch_pend),
		.fetch_done  (fetch_done),
		.prog_rdata  (prog_rdata),
		.prog_raddr  (prog_raddr),
		.rd_reg_addr (rd_reg_addr),
		.rd_dat_addr (rd_dat_addr),
		.ctl_next    (ctl_next)
	);

	fdec_prog_mem u_prog_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept && (in_data.func == fdec_pkg::FUNC_PROG)),
		.waddr  (in_data.load_addr[fdec_pkg::PROG_AW-1:0]),
		.wdata  (in_data.prog_word),
		.re     (accept),
		.raddr  (prog_raddr),
		.rdata  (prog_rdata)
	);

	fdec_exec_mem u_exec_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.rd_en       (accept),
		.rd_reg_addr (rd_reg_addr),
		.rd_dat_addr (rd_dat_addr),
		.reg_rdata   (reg_rdata),
		.dat_rdata   (dat_rdata)
	);

	// Write-back stage: hold the beat until it moves to the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s2 <= ctl_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld_q <= 1'b0;
		end else if (accept) begin
			s2_vld_q <= 1'b1;
		end else if (s2_adv) begin
			s2_vld_q <= 1'b0;
		end
	end

	// Store writes and result of the write-back stage
	always_comb begin
		wr.clear    = 1'b0;
		wr.reg_we   = 1'b0;
		wr.reg_addr = ctl_s2.op1[fdec_pkg::REG_AW-1:0];
		wr.reg_data = ctl_s2.op2;
		wr.dat_we   = 1'b0;
		wr.dat_addr = ctl_s2.op1[fdec_pkg::DATA_AW-1:0];
		wr.dat_data = reg_rdata;

		res.pc_now         = ctl_s2.pc;
		res.phase_now      = ctl_s2.phase;
		res.opcode_now     = ctl_s2.opcode;
		res.io_write_valid = 1'b0;
		res.io_write_addr  = 8'd0;
		res.io_write_data  = 8'd0;
		res.fault_reset    = 1'b0;

		case (ctl_s2.act)
			fdec_pkg::ACT_LDI: wr.reg_we = s2_adv;
			fdec_pkg::ACT_MOV: begin
				wr.reg_we   = s2_adv;
				wr.reg_data = reg_rdata;
			end
			fdec_pkg::ACT_IN: begin
				wr.reg_we   = s2_adv;
				wr.reg_data = dat_rdata;
			end
			fdec_pkg::ACT_OUT: begin
				wr.dat_we          = s2_adv;
				res.io_write_valid = 1'b1;
				res.io_write_addr  = 8'(ctl_s2.op1[fdec_pkg::DATA_AW-1:0]);
				res.io_write_data  = reg_rdata;
			end
			fdec_pkg::ACT_DWR: begin
				wr.dat_we   = s2_adv;
				wr.dat_addr = ctl_s2.load_addr[fdec_pkg::DATA_AW-1:0];
				wr.dat_data = ctl_s2.byte_in;
			end
			fdec_pkg::ACT_FAULT: begin
				wr.clear        = s2_adv;
				res.fault_reset = 1'b1;
			end
			default: wr.clear = 1'b0;
		endcase
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// Empty output register never blocks the input side
	`FDEC_ASSERT_IMPL(a_ready_when_empty, !out_vld_q, in_ready, "input stalled with empty output")
	// A stalled write-back beat must block new beats
	`FDEC_ASSERT_IMPL(a_stall_blocks, s2_vld_q && !s2_adv, !in_ready, "beat taken over a stall")
	// A fault result reports a core back at address zero in fetch
	`FDEC_ASSERT(a_fault_clean, !(out_vld_q && out_q.fault_reset) || (out_q.pc_now == 8'd0 && out_q.phase_now == fdec_pkg::PHC_FETCH && out_q.opcode_now == 8'd0), "fault result not clean")

endmodule

`default_nettype wire

// ===== rtl/fdec_prog_mem.sv =====
// ----------------------------------------------------------------------------
// fdec_prog_mem
// Program store: one write port, one registered read port, never-written
// entries read as NOP through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdec_prog_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [fdec_pkg::PROG_AW-1:0] waddr,
	input  logic [23:0]                wdata,
	input  logic                       re,
	input  logic [fdec_pkg::PROG_AW-1:0] raddr,
	output logic [23:0]                rdata
);

	logic [23:0]                     mem [fdec_pkg::PROG_DEPTH];
	logic [fdec_pkg::PROG_DEPTH-1:0] vld_q;
	logic [23:0]                     rd_q;
	logic                            rd_vld_q;

	// Array write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Track written entries; reset returns the whole store to NOP
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 24'd0;

endmodule

`default_nettype wire

// ===== rtl/fdec_exec_mem.sv =====
// ----------------------------------------------------------------------------
// fdec_exec_mem
// Register file and data store: registered reads, writes from the
// write-back stage, bypass of a write landing on the same edge as a read,
// and a clear of every entry at once through valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdec_exec_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fdec_pkg::exec_wr_t           wr,
	input  logic                         rd_en,
	input  logic [fdec_pkg::REG_AW-1:0]  rd_reg_addr,
	input  logic [fdec_pkg::DATA_AW-1:0] rd_dat_addr,
	output logic [7:0]                   reg_rdata,
	output logic [7:0]                   dat_rdata
);

	logic [7:0]                      reg_mem [fdec_pkg::NUM_REGS];
	logic [7:0]                      dat_mem [fdec_pkg::DATA_DEPTH];
	logic [fdec_pkg::NUM_REGS-1:0]   reg_vld_q;
	logic [fdec_pkg::DATA_DEPTH-1:0] dat_vld_q;

	logic [7:0] reg_rd_q;
	logic [7:0] dat_rd_q;
	logic [7:0] reg_byp_q;
	logic [7:0] dat_byp_q;
	logic       reg_rd_vld_q;
	logic       dat_rd_vld_q;
	logic       reg_byp_hit_q;
	logic       dat_byp_hit_q;

	// Array writes and registered reads
	always_ff @(posedge clk) begin
		if (wr.reg_we) begin
			reg_mem[wr.reg_addr] <= wr.reg_data;
		end
		if (wr.dat_we) begin
			dat_mem[wr.dat_addr] <= wr.dat_data;
		end
		if (rd_en) begin
			reg_rd_q  <= reg_mem[rd_reg_addr];
			dat_rd_q  <= dat_mem[rd_dat_addr];
			reg_byp_q <= wr.reg_data;
			dat_byp_q <= wr.dat_data;
		end
	end

	// Valid bits and bypass flags; clear drops every entry at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q     <= '0;
			dat_vld_q     <= '0;
			reg_rd_vld_q  <= 1'b0;
			dat_rd_vld_q  <= 1'b0;
			reg_byp_hit_q <= 1'b0;
			dat_byp_hit_q <= 1'b0;
		end else begin
			if (wr.clear) begin
				reg_vld_q <= '0;
				dat_vld_q <= '0;
			end else begin
				if (wr.reg_we) begin
					reg_vld_q[wr.reg_addr] <= 1'b1;
				end
				if (wr.dat_we) begin
					dat_vld_q[wr.dat_addr] <= 1'b1;
				end
			end
			if (rd_en) begin
				reg_rd_vld_q  <= !wr.clear && reg_vld_q[rd_reg_addr];
				dat_rd_vld_q  <= !wr.clear && dat_vld_q[rd_dat_addr];
				reg_byp_hit_q <= wr.reg_we && (wr.reg_addr == rd_reg_addr);
				dat_byp_hit_q <= wr.dat_we && (wr.dat_addr == rd_dat_addr);
			end
		end
	end

	// Pick bypassed, stored or cleared value
	assign reg_rdata = reg_byp_hit_q ? reg_byp_q : (reg_rd_vld_q ? reg_rd_q : 8'd0);
	assign dat_rdata = dat_byp_hit_q ? dat_byp_q : (dat_rd_vld_q ? dat_rd_q : 8'd0);

endmodule

`default_nettype wire

// ===== rtl/fdec_front.sv =====
// ----------------------------------------------------------------------------
// fdec_front
// Sequencer: program counter, phase, instruction and decoded fields.
// Updates at each accepted beat and tells the write-back stage what is left.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdec_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  fdec_pkg::in_t                item,
	input  logic                         fetch_pend,
	input  logic                         fetch_done,
	input  logic [23:0]                  prog_rdata,
	output logic [fdec_pkg::PROG_AW-1:0] prog_raddr,
	output logic [fdec_pkg::REG_AW-1:0]  rd_reg_addr,
	output logic [fdec_pkg::DATA_AW-1:0] rd_dat_addr,
	output fdec_pkg::ctl_t               ctl_next
);

	logic [7:0]       pc_q;
	fdec_pkg::phase_t phase_q;
	logic [7:0]       opcode_q;
	logic [7:0]       op1_q;
	logic [7:0]       op2_q;
	logic [23:0]      instr_q;

	logic [7:0]       pc_d;
	fdec_pkg::phase_t phase_d;
	logic [7:0]       opcode_d;
	logic [7:0]       op1_d;
	logic [7:0]       op2_d;
	logic [23:0]      word;
	fdec_pkg::act_t   act;
	logic             fault;

	// Fetched word still in flight comes straight from the program store
	assign word = fetch_pend ? prog_rdata : instr_q;

	// Next state for one beat
	always_comb begin
		pc_d     = pc_q;
		phase_d  = phase_q;
		opcode_d = opcode_q;
		op1_d    = op1_q;
		op2_d    = op2_q;
		act      = fdec_pkg::ACT_NONE;
		fault    = 1'b0;
		case (item.func)
			fdec_pkg::FUNC_DATA: act = fdec_pkg::ACT_DWR;
			fdec_pkg::FUNC_TICK: begin
				case (phase_q)
					fdec_pkg::PH_FETCH: begin
						pc_d    = pc_q + 8'd1;
						phase_d = fdec_pkg::PH_DECODE;
						act     = fdec_pkg::ACT_FETCH;
					end
					fdec_pkg::PH_DECODE: begin
						opcode_d = word[23:16];
						op1_d    = word[15:8];
						op2_d    = word[7:0];
						phase_d  = fdec_pkg::PH_EXECUTE;
					end
					fdec_pkg::PH_EXECUTE: begin
						phase_d = fdec_pkg::PH_FETCH;
						case (opcode_q)
							fdec_pkg::OPC_NOP: act = fdec_pkg::ACT_NONE;
							fdec_pkg::OPC_JMP: pc_d = op1_q;
							fdec_pkg::OPC_LDI: act = fdec_pkg::ACT_LDI;
							fdec_pkg::OPC_MOV: act = fdec_pkg::ACT_MOV;
							fdec_pkg::OPC_IN:  act = fdec_pkg::ACT_IN;
							fdec_pkg::OPC_OUT: act = fdec_pkg::ACT_OUT;
							default:           fault = 1'b1;
						endcase
					end
					default: fault = 1'b1;
				endcase
			end
			default: act = fdec_pkg::ACT_NONE;
		endcase
		// Unknown opcode or broken phase: drop back to a clean core
		if (fault) begin
			pc_d     = 8'd0;
			phase_d  = fdec_pkg::PH_FETCH;
			opcode_d = 8'd0;
			op1_d    = 8'd0;
			op2_d    = 8'd0;
			act      = fdec_pkg::ACT_FAULT;
		end
	end

	// Advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 8'd0;
			phase_q  <= fdec_pkg::PH_FETCH;
			opcode_q <= 8'd0;
			op1_q    <= 8'd0;
			op2_q    <= 8'd0;
			instr_q  <= 24'd0;
		end else begin
			if (accept) begin
				pc_q     <= pc_d;
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				op1_q    <= op1_d;
				op2_q    <= op2_d;
			end
			if (fetch_done) begin
				instr_q <= prog_rdata;
			end else if (accept && fault) begin
				instr_q <= 24'd0;
			end
		end
	end

	assign prog_raddr  = pc_q[fdec_pkg::PROG_AW-1:0];
	assign rd_reg_addr = op2_q[fdec_pkg::REG_AW-1:0];
	assign rd_dat_addr = op2_q[fdec_pkg::DATA_AW-1:0];

	always_comb begin
		ctl_next.act       = act;
		ctl_next.pc        = pc_d;
		ctl_next.phase     = fdec_pkg::phase_code(phase_d);
		ctl_next.opcode    = opcode_d;
		ctl_next.op1       = op1_q;
		ctl_next.op2       = op2_q;
		ctl_next.load_addr = item.load_addr;
		ctl_next.byte_in   = item.byte_in;
	end

endmodule

`default_nettype wire
